>>> src/alu_pkg.sv
package alu_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned KindWidth = 5;

  typedef enum logic [KindWidth-1:0] {
    K_MOV = 5'd0, K_ADD = 5'd1, K_SUB = 5'd2, K_CMP = 5'd3, K_MUL = 5'd4,
    K_DIV = 5'd5, K_AND = 5'd6, K_OR = 5'd7, K_XOR = 5'd8, K_NOT = 5'd9,
    K_SHL = 5'd10, K_SHR = 5'd11, K_SAR = 5'd12, K_LDL = 5'd13, K_LDH = 5'd14,
    K_JMP = 5'd15, K_JP = 5'd16, K_JN = 5'd17, K_JZ = 5'd18, K_JC = 5'd19,
    K_JV = 5'd20, K_JNP = 5'd21, K_JNN = 5'd22, K_JNZ = 5'd23
  } kind_t;

  typedef struct packed {
    logic [KindWidth-1:0] kind;
    logic [DataWidth-1:0] operand_a;
    logic [DataWidth-1:0] operand_b;
  } alu_in_t;

  typedef struct packed {
    logic [DataWidth-1:0] result_value;
    logic                 write_back;
    logic [DataWidth-1:0] remainder;
    logic                 remainder_valid;
    logic [3:0]           flags_out;
    logic                 divide_by_zero;
    logic                 take_branch;
  } alu_out_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_RUN, ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } ser_ctrl_t;

endpackage

>>> src/alu_serial_unit.sv
module alu_serial_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  alu_pkg::ser_ctrl_t        ctrl,
  input  logic [alu_pkg::KindWidth-1:0] kind,
  input  logic [alu_pkg::DataWidth-1:0] operand_a,
  input  logic [alu_pkg::DataWidth-1:0] operand_b,
  output logic [alu_pkg::DataWidth-1:0] acc_hi,
  output logic [alu_pkg::DataWidth-1:0] acc_lo,
  output logic                      carry_bit
);
  import alu_pkg::*;

  logic [DataWidth-1:0] hi, hi_next, lo, lo_next, mb;
  logic                 cb, cb_next;
  logic [DataWidth:0]   sum, diff;

  assign sum  = {1'b0, hi} + {1'b0, (lo[0] ? mb : '0)};
  assign diff = {hi[DataWidth-2:0], lo[DataWidth-1], 1'b0} >> 1;

  always_comb begin
    hi_next = hi;
    lo_next = lo;
    cb_next = cb;
    if (ctrl.start) begin
      hi_next = '0;
      lo_next = operand_a;
      cb_next = 1'b0;
    end else if (ctrl.busy) begin
      case (kind)
        K_MUL: begin
          hi_next = sum[DataWidth:1];
          lo_next = {sum[0], lo[DataWidth-1:1]};
        end
        K_DIV: begin
          if ({hi[DataWidth-1], diff[DataWidth-1:0]} >= {1'b0, mb}) begin
            hi_next = diff[DataWidth-1:0] - mb;
            lo_next = {lo[DataWidth-2:0], 1'b1};
          end else begin
            hi_next = diff[DataWidth-1:0];
            lo_next = {lo[DataWidth-2:0], 1'b0};
          end
        end
        K_SHL: begin
          cb_next = lo[DataWidth-1];
          lo_next = {lo[DataWidth-2:0], 1'b0};
        end
        K_SHR, K_SAR: begin
          cb_next = lo[0];
          lo_next = {(kind == K_SAR) ? lo[DataWidth-1] : 1'b0, lo[DataWidth-1:1]};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hi <= '0;
      lo <= '0;
      cb <= 1'b0;
    end else begin
      if (ctrl.start) mb <= operand_b;
      hi <= hi_next;
      lo <= lo_next;
      cb <= cb_next;
    end
  end

  assign acc_hi    = hi;
  assign acc_lo    = lo;
  assign carry_bit = cb;

endmodule

>>> src/alu_with_condition_flags.sv
// Each word carries an operation code and two 32-bit operands and yields one result word with
// the value, write-back, remainder and updated N/Z/C/V flags. After acceptance, single-step
// operations leave the run state at once, shifts by 1 to 31 step once per bit of the count, and
// mul, div and shifts by 32 or more step once per data bit, since the shared shift/add/subtract
// unit handles one bit per cycle. The flag register updates as each result word is loaded into
// the output register; a new word is accepted the cycle after the previous result has been
// taken.
module alu_with_condition_flags (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  alu_pkg::alu_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output alu_pkg::alu_out_t out_data
);
  import alu_pkg::*;

  state_t state, state_next;
  alu_in_t held;
  logic [3:0] flags, flags_next;
  logic [5:0] steps, steps_next;
  ser_ctrl_t ctrl;
  logic [DataWidth-1:0] acc_hi, acc_lo;
  logic carry_bit, take, serial_kind;
  alu_out_t res;
  logic [DataWidth:0] add_w, sub_w;

  assign take = in_valid && !in_stall;
  assign serial_kind = (in_data.kind == K_MUL) ||
                       (in_data.kind == K_DIV && in_data.operand_b != '0) ||
                       ((in_data.kind == K_SHL || in_data.kind == K_SHR ||
                         in_data.kind == K_SAR) && in_data.operand_b != '0);

  always_comb begin
    state_next = state;
    steps_next = steps;
    case (state)
      ST_IDLE: if (take) begin
        state_next = ST_RUN;
        if (!serial_kind) steps_next = '0;
        else if (in_data.kind == K_MUL || in_data.kind == K_DIV) steps_next = 6'd32;
        else if (in_data.operand_b >= 32'd32) steps_next = 6'd32;
        else steps_next = {1'b0, in_data.operand_b[4:0]};
      end
      ST_RUN: begin
        if (steps == '0) state_next = ST_DONE;
        else steps_next = steps - 6'd1;
      end
      ST_DONE: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.start = take;
    ctrl.busy  = (state == ST_RUN) && (steps != '0);
    in_stall   = (state != ST_IDLE);
    out_valid  = (state == ST_DONE);
  end

  alu_serial_unit u_ser (
    .clk(clk), .rst(rst), .ctrl(ctrl),
    .kind(take ? in_data.kind : held.kind),
    .operand_a(in_data.operand_a), .operand_b(in_data.operand_b),
    .acc_hi(acc_hi), .acc_lo(acc_lo), .carry_bit(carry_bit)
  );

  assign add_w = {1'b0, held.operand_a} + {1'b0, held.operand_b};
  assign sub_w = {1'b0, held.operand_a} - {1'b0, held.operand_b};

  function automatic logic [3:0] nzf(logic [DataWidth-1:0] r, logic c, logic v);
    return {r[DataWidth-1], r == '0, c, v};
  endfunction

  always_comb begin
    logic [DataWidth-1:0] a, b;
    logic sa, sb, big;
    a = held.operand_a;
    b = held.operand_b;
    sa = a[DataWidth-1];
    sb = b[DataWidth-1];
    big = b > 32'd32;
    res = '0;
    flags_next = flags;
    case (held.kind)
      K_MOV: begin res.result_value = b; res.write_back = 1'b1;
        flags_next = nzf(b, 1'b0, 1'b0); end
      K_ADD: begin res.result_value = add_w[DataWidth-1:0]; res.write_back = 1'b1;
        flags_next = nzf(add_w[DataWidth-1:0], add_w[DataWidth],
                         sa == sb && sa != add_w[DataWidth-1]); end
      K_SUB, K_CMP: begin res.result_value = sub_w[DataWidth-1:0];
        res.write_back = (held.kind == K_SUB);
        flags_next = nzf(sub_w[DataWidth-1:0], sub_w[DataWidth],
                         sa != sb && sa != sub_w[DataWidth-1]); end
      K_MUL: begin res.result_value = acc_lo; res.write_back = 1'b1;
        flags_next = nzf(acc_lo, acc_hi != '0, acc_hi != '0); end
      K_DIV: begin
        if (b == '0) res.divide_by_zero = 1'b1;
        else begin
          res.result_value = acc_lo; res.remainder = acc_hi;
          res.write_back = 1'b1; res.remainder_valid = 1'b1;
          flags_next = nzf(acc_lo, 1'b0, 1'b0);
        end
      end
      K_AND: begin res.result_value = a & b; res.write_back = 1'b1;
        flags_next = nzf(a & b, 1'b0, 1'b0); end
      K_OR: begin res.result_value = a | b; res.write_back = 1'b1;
        flags_next = nzf(a | b, 1'b0, 1'b0); end
      K_XOR: begin res.result_value = a ^ b; res.write_back = 1'b1;
        flags_next = nzf(a ^ b, 1'b0, 1'b0); end
      K_NOT: begin res.result_value = ~a; res.write_back = 1'b1;
        flags_next = nzf(~a, 1'b0, 1'b0); end
      K_SHL, K_SHR, K_SAR: begin
        res.result_value = (b == '0) ? a : acc_lo;
        res.write_back = 1'b1;
        flags_next = nzf(res.result_value, (b != '0) && !big && carry_bit, 1'b0);
      end
      K_LDL: begin res.result_value = {a[31:16], b[15:0]}; res.write_back = 1'b1; end
      K_LDH: begin res.result_value = {b[15:0], a[15:0]}; res.write_back = 1'b1; end
      K_JMP: res.take_branch = 1'b1;
      K_JP:  res.take_branch = !flags[3] && !flags[2];
      K_JN:  res.take_branch = flags[3];
      K_JZ:  res.take_branch = flags[2];
      K_JC:  res.take_branch = flags[1];
      K_JV:  res.take_branch = flags[0];
      K_JNP: res.take_branch = flags[3] || flags[2];
      K_JNN: res.take_branch = !flags[3] || flags[2];
      K_JNZ: res.take_branch = !flags[2];
      default: ;
    endcase
    res.flags_out = flags_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      flags <= '0;
      steps <= '0;
    end else begin
      state <= state_next;
      steps <= steps_next;
      if (state == ST_RUN && steps == '0) flags <= flags_next;
    end
    if (take) held <= in_data;
    if (state == ST_RUN && steps == '0) out_data <= res;
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("accepted while busy");
  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    steps <= 6'd32) else $error("step count out of range");
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |=> $stable(flags)) else $error("flags moved while done");
  a_done_follow: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && steps == '0) |=> out_valid) else $error("result lost");

endmodule
